### src/fbpsb_pkg.sv
package fbpsb_pkg;

  localparam int DEPTH = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CQ_DEPTH = 2;
  localparam int OQ_DEPTH = 2;

  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_PEEK_FRONT = 3'd3;
  localparam logic [2:0] REQ_LIST_ALL   = 3'd4;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] data_value;
    logic [1:0]         status;
    logic               is_last;
    logic               now_empty;
  } res_t;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] r;
    if (idx == IDX_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = idx + 1'b1;
    end
    return r;
  endfunction

endpackage

### src/fbpsb_front.sv
module fbpsb_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [2:0]           in_req_type,
  input  logic signed [31:0]   in_push_value,
  output logic                 cmd_valid,
  output fbpsb_pkg::cmd_t      cmd,
  input  logic                 cmd_take
);
  import fbpsb_pkg::*;

  cmd_t       q_r [CQ_DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       acc, known, enq, deq;

  assign in_full   = (cnt_r == 2'(CQ_DEPTH));
  assign acc       = in_push && !in_full;
  assign known     = (in_req_type inside {[REQ_PUSH_FRONT:REQ_LIST_ALL]});
  assign enq       = acc && known;
  assign cmd_valid = (cnt_r != 2'd0);
  assign deq       = cmd_take && cmd_valid;
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = enq ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = deq ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, enq} - {1'b0, deq};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q_r[wr_ptr_r] <= '{req_type: in_req_type, value: in_push_value};
    end
  end

endmodule

### src/fbpsb_back.sv
module fbpsb_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_valid,
  input  fbpsb_pkg::cmd_t      cmd,
  output logic                 cmd_take,
  output logic                 out_empty,
  input  logic                 out_pop,
  output fbpsb_pkg::res_t      res
);
  import fbpsb_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [31:0]      mem [DEPTH];
  logic [31:0]      rd_data_r;

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] addr_r, addr_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic             pend_empty_r, pend_empty_nxt;

  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [CNT_W:0]   back_sum;
  logic [IDX_W-1:0] back_idx;

  res_t             oq_r [OQ_DEPTH];
  logic             oq_wp_r, oq_rp_r;
  logic [1:0]       oq_cnt_r, oq_cnt_nxt;
  logic             oq_we, oq_re;
  res_t             oq_wdata;
  logic             oq_full;

  assign oq_full   = (oq_cnt_r == 2'(OQ_DEPTH));
  assign out_empty = (oq_cnt_r == 2'd0);
  assign oq_re     = out_pop && !out_empty;
  assign res       = oq_r[oq_rp_r];

  assign back_sum = {1'b0, CNT_W'(head_r)} + {1'b0, count_r};
  assign back_idx = (back_sum >= (CNT_W+1)'(DEPTH)) ?
                    IDX_W'(back_sum - (CNT_W+1)'(DEPTH)) : IDX_W'(back_sum);

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    addr_nxt       = addr_r;
    left_nxt       = left_r;
    pend_empty_nxt = pend_empty_r;
    cmd_take       = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = back_idx;
    mem_re         = 1'b0;
    mem_raddr      = head_r;
    oq_we          = 1'b0;
    oq_wdata       = '{data_value: '0, status: STAT_OK, is_last: 1'b1,
                       now_empty: 1'b0};
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid && !oq_full) begin
          cmd_take = 1'b1;
          case (cmd.req_type)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
              oq_we = 1'b1;
              if (count_r == CNT_W'(DEPTH)) begin
                oq_wdata.status = STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                count_nxt = count_r + 1'b1;
                if (cmd.req_type == REQ_PUSH_FRONT) begin
                  mem_waddr = (head_r == '0) ? IDX_W'(DEPTH - 1) : head_r - 1'b1;
                  head_nxt  = mem_waddr;
                end
              end
              oq_wdata.now_empty = (count_r == '0) && (count_r == CNT_W'(DEPTH));
            end
            REQ_POP_FRONT, REQ_PEEK_FRONT, REQ_LIST_ALL: begin
              if (count_r == '0) begin
                oq_we              = 1'b1;
                oq_wdata.status    = STAT_EMPTY;
                oq_wdata.now_empty = 1'b1;
              end else begin
                mem_re         = 1'b1;
                addr_nxt       = head_r;
                left_nxt       = (cmd.req_type == REQ_LIST_ALL) ? count_r : CNT_W'(1);
                pend_empty_nxt = 1'b0;
                state_nxt      = ST_READ;
                if (cmd.req_type == REQ_POP_FRONT) begin
                  head_nxt       = idx_inc(head_r);
                  count_nxt      = count_r - 1'b1;
                  pend_empty_nxt = (count_r == CNT_W'(1));
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        oq_we               = 1'b1;
        oq_wdata.data_value = rd_data_r;
        oq_wdata.is_last    = (left_r == CNT_W'(1));
        oq_wdata.now_empty  = pend_empty_r;
        if (left_r != CNT_W'(1)) begin
          addr_nxt = idx_inc(addr_r);
          left_nxt = left_r - 1'b1;
          if (oq_cnt_r == 2'd0) begin
            mem_re    = 1'b1;
            mem_raddr = idx_inc(addr_r);
          end else begin
            state_nxt = ST_WAIT;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_WAIT: begin
        mem_raddr = addr_r;
        if (!oq_full) begin
          mem_re    = 1'b1;
          state_nxt = ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    oq_cnt_nxt = oq_cnt_r + {1'b0, oq_we} - {1'b0, oq_re};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      head_r       <= '0;
      count_r      <= '0;
      addr_r       <= '0;
      left_r       <= '0;
      pend_empty_r <= 1'b0;
      oq_wp_r      <= 1'b0;
      oq_rp_r      <= 1'b0;
      oq_cnt_r     <= '0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      count_r      <= count_nxt;
      addr_r       <= addr_nxt;
      left_r       <= left_nxt;
      pend_empty_r <= pend_empty_nxt;
      oq_wp_r      <= oq_we ? !oq_wp_r : oq_wp_r;
      oq_rp_r      <= oq_re ? !oq_rp_r : oq_rp_r;
      oq_cnt_r     <= oq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= cmd.value;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (oq_we) begin
      oq_r[oq_wp_r] <= oq_wdata;
    end
  end

endmodule

### src/front_back_push_sequence_buffer.sv
// A push result passes through the command queue and the result queue; pop,
// peek and each listed entry also pass through the registered store read.
// Throughput: one push per cycle while the result queue has room; pop and peek hold the
// back end for the store read; a list reads ahead only into an empty result queue.
// Reset (rst_n low, synchronous): both queues empty, buffer empty, head at
// slot 0; store contents stay undefined until written.
module front_back_push_sequence_buffer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [2:0]           in_req_type,
  input  logic signed [31:0]   in_push_value,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic signed [31:0]   out_data_value,
  output logic [1:0]           out_status,
  output logic                 out_is_last,
  output logic                 out_now_empty
);
  import fbpsb_pkg::*;

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;
  res_t res;

  fbpsb_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_req_type   (in_req_type),
    .in_push_value (in_push_value),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_take      (cmd_take)
  );

  fbpsb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .res       (res)
  );

  assign out_data_value = res.data_value;
  assign out_status     = res.status;
  assign out_is_last    = res.is_last;
  assign out_now_empty  = res.now_empty;

endmodule

### src/fbpsb_chk.sv
module fbpsb_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_full,
  input logic                 out_empty,
  input logic                 out_pop,
  input logic signed [31:0]   out_data_value,
  input logic [1:0]           out_status,
  input logic                 out_is_last,
  input logic                 out_now_empty
);
  import fbpsb_pkg::*;

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status == STAT_FULL) |->
      (out_data_value == 32'sd0 && out_is_last && !out_now_empty))
    else $error("bad full-status transaction");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status == STAT_EMPTY) |->
      (out_data_value == 32'sd0 && out_is_last && out_now_empty))
    else $error("bad empty-status transaction");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_status == STAT_OK || out_status == STAT_EMPTY ||
                    out_status == STAT_FULL))
    else $error("undefined status code");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data_value) &&
                                  $stable(out_is_last)))
    else $error("stalled result changed");

endmodule

bind front_back_push_sequence_buffer fbpsb_chk u_fbpsb_chk (.*);
